// File: rtl/stm_pkg.sv
// Package for the slot timer multiplexer: word types, command and event codes,
// run cap and guard constants. No dependencies.
package stm_pkg;

  localparam int MAX_RUN      = 8;
  localparam int RESULT_SLOTS = 8;
  localparam int RUN_CAP      = (MAX_RUN < RESULT_SLOTS) ? MAX_RUN : RESULT_SLOTS;
  localparam int CNT_W        = $clog2(RUN_CAP + 1);

  localparam logic [15:0] WRAP_LIMIT  = 16'd65000;
  localparam logic [7:0]  GUARD_RESET = 8'd2;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_PERIOD = 3'd2;
  localparam logic [2:0] CMD_SCHED  = 3'd3;
  localparam logic [2:0] CMD_CANCEL = 3'd4;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_OVF  = 2'd1;
  localparam logic [1:0] EV_CMP  = 2'd2;

  // pending firing, one-hot
  localparam logic [1:0] PEND_NONE = 2'b00;
  localparam logic [1:0] PEND_OVF  = 2'b01;
  localparam logic [1:0] PEND_CMP  = 2'b10;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic        late;
    logic [15:0] elapsed;
    logic [15:0] period_now;
    logic        overrun;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch input word
    logic apply;  // execute command
    logic init;   // match check, start of firing run
    logic sel;    // reselect after commands 1 to 4
    logic fire;   // fire pending timer
    logic next;   // reselect, guard check, result capture
    logic cap;    // run count reached the cap
  } stm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic fire_go;
    logic res_last;
  } stm_sts_t;

endpackage

// File: rtl/stm_ctrl.sv
// Sequencer for the slot timer multiplexer: handshake, step order, run count.
// Depends on stm_pkg.
module stm_ctrl
  import stm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  stm_sts_t sts_i,
  output stm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_INIT,
    S_SEL,
    S_FIRE,
    S_NEXT,
    S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             cap;

  assign cap = (cnt_q >= CNT_W'(RUN_CAP));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d = sts_i.is_tick ? S_INIT : S_SEL;
      end
      S_INIT: begin
        cnt_d   = '0;
        state_d = sts_i.fire_go ? S_FIRE : S_OUT;
      end
      S_SEL: begin
        state_d = S_OUT;
      end
      S_FIRE: begin
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = S_NEXT;
      end
      S_NEXT: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = sts_i.res_last ? S_IDLE : S_FIRE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.apply = (state_q == S_APPLY);
    cmd_o.init  = (state_q == S_INIT);
    cmd_o.sel   = (state_q == S_SEL);
    cmd_o.fire  = (state_q == S_FIRE);
    cmd_o.next  = (state_q == S_NEXT);
    cmd_o.cap   = cap;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides open together");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RUN_CAP))
    else $error("run count past cap");

  a_fire_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIRE) |-> ($past(state_q) == S_INIT || $past(state_q) == S_OUT))
    else $error("firing step entered out of order");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && sts_i.res_last) |=> in_ready_o)
    else $error("not idle after final word");

endmodule

// File: rtl/stm_dp.sv
// Datapath for the slot timer multiplexer: counter, due times, match select,
// guard check and result word. Depends on stm_pkg.
module stm_dp
  import stm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  logic      cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  input  stm_cmd_t  cmd_i,
  output stm_sts_t  sts_o,
  output out_item_t out_data_o
);

  logic [2:0]  op_q;
  logic [15:0] val_q;
  logic [7:0]  guard_q;
  logic [15:0] tick_q, svc_q, match_q, ovf_due_q, cmp_due_q;
  logic [15:0] period_q, prev_ovf_q, offset_q;
  logic        match_act_q, ovf_arm_q, cmp_arm_q, late_q;
  logic [1:0]  pend_q;
  out_item_t   res_q;

  // nearest armed timer after the service time
  logic [15:0] d_ovf, d_cmp, sel_pick;
  logic        sel_found, sel_cmp;

  assign d_ovf     = ovf_due_q - svc_q;
  assign d_cmp     = cmp_due_q - svc_q;
  assign sel_cmp   = cmp_arm_q && (!ovf_arm_q || (d_cmp < d_ovf));
  assign sel_found = ovf_arm_q || cmp_arm_q;
  assign sel_pick  = sel_cmp ? cmp_due_q : ovf_due_q;

  // guard rule: timers already within reach are fired late
  logic [15:0] spent_raw, spent;
  logic        ovf_ok, cmp_ok;
  logic [1:0]  pend_nx;
  logic [15:0] pend_pick;

  assign spent_raw = tick_q - svc_q + {8'h00, guard_q};
  assign spent     = (spent_raw > WRAP_LIMIT) ? {8'h00, guard_q} : spent_raw;
  assign ovf_ok    = ovf_arm_q && (spent > d_ovf);
  assign cmp_ok    = cmp_arm_q && (spent > d_cmp) && (!ovf_ok || (d_cmp < d_ovf));

  always_comb begin
    pend_nx   = PEND_NONE;
    pend_pick = ovf_due_q;
    if (cmp_ok) begin
      pend_nx   = PEND_CMP;
      pend_pick = cmp_due_q;
    end else if (ovf_ok) begin
      pend_nx = PEND_OVF;
    end
  end

  // start of a run
  logic       hit, ovf_hit, cmp_hit;
  logic [1:0] pend0;

  assign hit     = match_act_q && (tick_q == match_q);
  assign ovf_hit = ovf_arm_q && (ovf_due_q == match_q);
  assign cmp_hit = cmp_arm_q && (cmp_due_q == match_q);
  assign pend0   = ovf_hit ? PEND_OVF : (cmp_hit ? PEND_CMP : PEND_NONE);

  logic op_resel;
  assign op_resel = (op_q == CMD_START) || (op_q == CMD_PERIOD) ||
                    (op_q == CMD_SCHED) || (op_q == CMD_CANCEL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.command;
      val_q <= in_data_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q     <= GUARD_RESET;
      tick_q      <= '0;
      svc_q       <= '0;
      match_q     <= '0;
      match_act_q <= 1'b0;
      ovf_arm_q   <= 1'b0;
      cmp_arm_q   <= 1'b0;
      ovf_due_q   <= '0;
      cmp_due_q   <= '0;
      period_q    <= '0;
      prev_ovf_q  <= '0;
      offset_q    <= '0;
      late_q      <= 1'b0;
      pend_q      <= PEND_NONE;
    end else begin
      if (cfg_valid_i) guard_q <= cfg_data_i;

      if (cmd_i.apply) begin
        case (op_q)
          CMD_TICK: tick_q <= tick_q + 16'd1;
          CMD_START: begin
            period_q   <= val_q;
            prev_ovf_q <= ovf_due_q;
            ovf_due_q  <= ovf_due_q + val_q;
            ovf_arm_q  <= 1'b1;
          end
          CMD_PERIOD: begin
            period_q  <= val_q + 16'd1;
            ovf_due_q <= prev_ovf_q + val_q + 16'd1;
          end
          CMD_SCHED: begin
            offset_q  <= val_q;
            cmp_due_q <= prev_ovf_q + val_q;
            cmp_arm_q <= 1'b1;
          end
          CMD_CANCEL: cmp_arm_q <= 1'b0;
          default: ;
        endcase
      end

      if (cmd_i.sel && op_resel) begin
        match_act_q <= sel_found;
        if (sel_found) match_q <= sel_pick;
      end

      if (cmd_i.init && hit) begin
        svc_q  <= match_q;
        pend_q <= pend0;
        late_q <= 1'b0;
      end

      if (cmd_i.fire) begin
        if (pend_q[0]) begin
          prev_ovf_q <= ovf_due_q;
          ovf_due_q  <= ovf_due_q + period_q;
        end else begin
          cmp_due_q <= ovf_due_q + offset_q;
        end
      end

      if (cmd_i.next) begin
        match_act_q <= sel_found;
        pend_q      <= pend_nx;
        if (pend_nx != PEND_NONE) begin
          match_q <= pend_pick;
          svc_q   <= pend_pick;
          late_q  <= 1'b1;
        end else if (sel_found) begin
          match_q <= sel_pick;
        end
      end
    end
  end

  // result word; a no-firing word is loaded on init/sel and replaced if a run fires
  always_ff @(posedge clk_i) begin
    if (cmd_i.init || cmd_i.sel) begin
      res_q.event_res  <= EV_NONE;
      res_q.late       <= 1'b0;
      res_q.elapsed    <= tick_q - prev_ovf_q;
      res_q.period_now <= period_q;
      res_q.overrun    <= 1'b0;
      res_q.last       <= 1'b1;
    end else if (cmd_i.next) begin
      res_q.event_res  <= pend_q[0] ? EV_OVF : EV_CMP;
      res_q.late       <= late_q;
      res_q.elapsed    <= tick_q - prev_ovf_q;
      res_q.period_now <= period_q;
      res_q.overrun    <= (pend_nx != PEND_NONE) && cmd_i.cap;
      res_q.last       <= (pend_nx == PEND_NONE) || cmd_i.cap;
    end
  end

  assign out_data_o       = res_q;
  assign sts_o.is_tick    = (op_q == CMD_TICK);
  assign sts_o.fire_go    = hit && (pend0 != PEND_NONE);
  assign sts_o.res_last   = res_q.last;

endmodule

// File: rtl/slot_timer_multiplexer_unit.sv
// Steps: an accepted word is applied, then goes through the select step or, for a
// tick, the match check; no new input word is taken until its last result word is
// taken. A tick that fires adds fire and guard check before its first word, and
// output, fire and guard check per further firing, up to RUN_CAP firings per word.
// Reset (async, active low) clears all timer state to zero, the guard register to 2.
// Top level of the slot timer multiplexer; uses stm_pkg, stm_ctrl, stm_dp.
module slot_timer_multiplexer_unit
  import stm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  stm_cmd_t cmd;
  stm_sts_t sts;
  logic     cfg_we;

  // guard register is written only while idle
  assign cfg_ready_o = in_ready_o && !in_valid_i;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  stm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  stm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/slot_timer_multiplexer_unit_tb.sv
// Testbench for slot_timer_multiplexer_unit: drives tick and timer commands, predicts
// each result word with a behavioral timer model and checks the output stream in order.
// Depends on stm_pkg and the slot_timer_multiplexer_unit RTL only.
module slot_timer_multiplexer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stm_pkg::*;

  localparam int          CLK_PERIOD   = 20;
  localparam int unsigned RUN_LIMIT_NS = 10_000_000;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = '0;

  slot_timer_multiplexer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // timer model state, mirrors the block after reset
  logic [15:0] tick_cnt   = '0;
  logic [15:0] svc_time   = '0;
  logic [15:0] match_at   = '0;
  logic        match_on   = 1'b0;
  logic        ovf_armed  = 1'b0;
  logic        cmp_armed  = 1'b0;
  logic [15:0] ovf_due    = '0;
  logic [15:0] cmp_due    = '0;
  logic [15:0] period_reg = '0;
  logic [15:0] prev_ovf   = '0;
  logic [15:0] cmp_offset = '0;
  logic [7:0]  guard_q    = GUARD_RESET;

  out_item_t slot_run[$];
  out_item_t expected_events[$];
  out_item_t want_w;

  int unsigned src_idle_pct   = 19;
  int unsigned sink_idle_pct  = 19;
  int unsigned hold_off       = 0;
  int unsigned accepted_items = 0;
  int unsigned mismatches     = 0;
  int unsigned words_checked  = 0;
  int unsigned firings_seen   = 0;
  int unsigned late_seen      = 0;
  int unsigned overruns_seen  = 0;
  int unsigned guard_writes   = 0;

  function automatic out_item_t slot_word(input logic [1:0] ev, input logic late);
    out_item_t w;
    w.event_res  = ev;
    w.late       = late;
    w.elapsed    = tick_cnt - prev_ovf;
    w.period_now = period_reg;
    w.overrun    = 1'b0;
    w.last       = 1'b0;
    return w;
  endfunction

  // nearest armed timer after the service time, overflow wins a tie
  function automatic void pick_match();
    logic [15:0] best;
    logic [15:0] gap;
    logic        found;
    found = 1'b0;
    best  = 16'hffff;
    if (ovf_armed) begin
      best     = ovf_due - svc_time;
      match_at = ovf_due;
      found    = 1'b1;
    end
    if (cmp_armed) begin
      gap = cmp_due - svc_time;
      if (!found || gap < best) begin
        match_at = cmp_due;
        found    = 1'b1;
      end
    end
    match_on = found;
  endfunction

  function automatic void fire_slot_run();
    logic [1:0]  pend;
    logic        late;
    logic [15:0] spent;
    logic [15:0] calc;
    logic [15:0] lowest;
    logic [15:0] pick;
    out_item_t   w;
    pend     = PEND_NONE;
    late     = 1'b0;
    pick     = '0;
    svc_time = match_at;
    if (ovf_armed && ovf_due == svc_time) pend |= PEND_OVF;
    if (cmp_armed && cmp_due == svc_time) pend |= PEND_CMP;
    // overflow wins when the compare lands on it; the compare may still fire late via the guard check
    if (pend == (PEND_OVF | PEND_CMP)) pend = PEND_OVF;
    while (pend != PEND_NONE) begin
      if (slot_run.size() >= RUN_CAP) begin
        w = slot_run.pop_back();
        w.overrun = 1'b1;
        slot_run.push_back(w);
        break;
      end
      if (pend == PEND_OVF) begin
        prev_ovf = ovf_due;
        ovf_due  = ovf_due + period_reg;
        slot_run.push_back(slot_word(EV_OVF, late));
      end else begin
        cmp_due = ovf_due + cmp_offset;
        slot_run.push_back(slot_word(EV_CMP, late));
      end
      pick_match();
      spent = tick_cnt - svc_time + {8'h00, guard_q};
      if (spent > WRAP_LIMIT) spent = {8'h00, guard_q};
      pend   = PEND_NONE;
      lowest = 16'hffff;
      calc   = ovf_due - svc_time;
      if (ovf_armed && spent > calc && calc < lowest) begin
        lowest = calc;
        pend   = PEND_OVF;
        pick   = ovf_due;
      end
      calc = cmp_due - svc_time;
      if (cmp_armed && spent > calc && calc < lowest) begin
        lowest = calc;
        pend   = PEND_CMP;
        pick   = cmp_due;
      end
      if (pend != PEND_NONE) begin
        match_at = pick;
        svc_time = pick;
        late     = 1'b1;
      end
    end
  endfunction

  function automatic void predict_slot_events(input logic [2:0] cmd, input logic [15:0] val);
    out_item_t w;
    slot_run.delete();
    case (cmd)
      CMD_TICK: begin
        tick_cnt = tick_cnt + 16'd1;
        if (match_on && tick_cnt == match_at) fire_slot_run();
      end
      CMD_START: begin
        period_reg = val;
        prev_ovf   = ovf_due;
        ovf_due    = ovf_due + val;
        ovf_armed  = 1'b1;
      end
      CMD_PERIOD: begin
        period_reg = val + 16'd1;
        ovf_due    = prev_ovf + period_reg;
      end
      CMD_SCHED: begin
        cmp_offset = val;
        cmp_due    = prev_ovf + val;
        cmp_armed  = 1'b1;
      end
      CMD_CANCEL: cmp_armed = 1'b0;
      default: ;
    endcase
    if (cmd != CMD_TICK && cmd <= CMD_CANCEL) pick_match();
    if (slot_run.size() == 0) slot_run.push_back(slot_word(EV_NONE, 1'b0));
    w = slot_run.pop_back();
    w.last = 1'b1;
    slot_run.push_back(w);
    foreach (slot_run[k]) expected_events.push_back(slot_run[k]);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: word %0d %s: got %0h, want %0h", $time, words_checked, what, got, want);
  endtask

  task automatic send_word(input logic [2:0] cmd, input logic [15:0] val);
    in_item_t w;
    w.command = cmd;
    w.value   = val;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_slot_events(cmd, val);
    if (cmd <= CMD_CANCEL) accepted_items++;
  endtask

  task automatic load_guard(input logic [7:0] g);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    guard_q = g;
    guard_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // put the overflow just ahead of the counter, let it fire once, then set a short
  // period and optionally a compare at most three ticks past the next overflow
  task automatic anchor_slot(input logic [15:0] p, input logic with_cmp);
    logic [15:0] lead;
    lead = 16'($urandom_range(3));
    send_word(CMD_CANCEL, 16'($urandom));
    send_word(CMD_START, tick_cnt - ovf_due + 16'd1 + lead);
    repeat (lead + 1) send_word(CMD_TICK, 16'($urandom));
    send_word(CMD_PERIOD, p - 16'd1);
    if (with_cmp)
      send_word(CMD_SCHED, tick_cnt - prev_ovf + 16'd1 + 16'($urandom_range(p + 2)));
  endtask

  task automatic test_commands_directed();
    send_word(CMD_TICK, 16'hffff);
    for (int c = CMD_CANCEL + 1; c < 8; c++) send_word(3'(c), 16'($urandom));
    send_word(CMD_CANCEL, 16'hffff);
    send_word(CMD_START, 16'd3);
    send_word(CMD_SCHED, 16'd2);
    send_word(CMD_TICK, 16'h0000);  // compare fires, overflow follows late
    send_word(CMD_TICK, 16'($urandom));
    send_word(CMD_SCHED, 16'd3);    // compare lands on the next overflow
    repeat (3) send_word(CMD_TICK, 16'($urandom));
    send_word(CMD_PERIOD, 16'hffff);
    send_word(CMD_START, 16'hffff);
    send_word(CMD_SCHED, 16'hffff);
    send_word(CMD_SCHED, 16'h0000);
    send_word(CMD_START, 16'h0000);
    send_word(CMD_PERIOD, 16'h0000);
    send_word(CMD_TICK, 16'($urandom));
  endtask

  task automatic test_run_cap();
    wait_quiet();
    load_guard(8'd40);
    anchor_slot(16'd1, 1'b0);
    repeat (6) send_word(CMD_TICK, 16'($urandom));
  endtask

  task automatic test_output_stall();
    src_idle_pct = 0;
    anchor_slot(16'd3, 1'b1);
    hold_off = 120;
    repeat (24) send_word(CMD_TICK, 16'($urandom));
    src_idle_pct = 19;
  endtask

  task automatic test_random_slots(input logic [7:0] guard, input int unsigned n_items,
                                   input int unsigned idle_pct);
    int unsigned stop_at;
    int unsigned n_ticks;
    logic [15:0] p;
    wait_quiet();
    load_guard(guard);
    src_idle_pct  = idle_pct;
    sink_idle_pct = idle_pct;
    stop_at = accepted_items + n_items;
    while (accepted_items < stop_at) begin
      if ($urandom_range(5) == 0) p = 16'($urandom_range(400, 25));
      else p = 16'($urandom_range(24, 1));
      anchor_slot(p, $urandom_range(3) != 0);
      n_ticks = $urandom_range(40, 12);
      repeat (n_ticks) begin
        if ($urandom_range(99) < 6) send_word(3'($urandom_range(7)), 16'($urandom));
        else send_word(CMD_TICK, 16'($urandom));
      end
    end
    src_idle_pct  = 19;
    sink_idle_pct = 19;
  endtask

  always @(negedge clk_i) begin
    if (hold_off != 0) begin
      hold_off = hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (out_data_o.event_res != EV_NONE) firings_seen++;
      if (out_data_o.late) late_seen++;
      if (out_data_o.overrun) overruns_seen++;
      if (expected_events.size() == 0) begin
        report_mismatch("word with nothing expected, event", 16'(out_data_o.event_res),
                        16'(EV_NONE));
      end else begin
        want_w = expected_events.pop_front();
        if (out_data_o.event_res !== want_w.event_res)
          report_mismatch("event", 16'(out_data_o.event_res), 16'(want_w.event_res));
        if (out_data_o.late !== want_w.late)
          report_mismatch("late", 16'(out_data_o.late), 16'(want_w.late));
        if (out_data_o.elapsed !== want_w.elapsed)
          report_mismatch("elapsed", out_data_o.elapsed, want_w.elapsed);
        if (out_data_o.period_now !== want_w.period_now)
          report_mismatch("period", out_data_o.period_now, want_w.period_now);
        if (out_data_o.overrun !== want_w.overrun)
          report_mismatch("overrun", 16'(out_data_o.overrun), 16'(want_w.overrun));
        if (out_data_o.last !== want_w.last)
          report_mismatch("last", 16'(out_data_o.last), 16'(want_w.last));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_commands_directed();
    test_run_cap();
    test_output_stall();
    test_random_slots(8'd0, 65, 19);
    test_random_slots(8'd255, 65, 19);
    test_random_slots(8'($urandom_range(254, 1)), 65, 0);  // no idling on either side
    test_random_slots(GUARD_RESET, 65, 19);
    wait_quiet();
    $display("Covered %0d commands and %0d result words: %0d firings, %0d late, %0d capped.",
             accepted_items, words_checked, firings_seen, late_seen, overruns_seen);
    $display("Guard register written %0d times; %0d mismatches, %0d words still owed.",
             guard_writes, mismatches, expected_events.size());
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run timed out with %0d words still owed.", expected_events.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/stm_pkg.sv
rtl/stm_ctrl.sv
rtl/stm_dp.sv
rtl/slot_timer_multiplexer_unit.sv
tb/slot_timer_multiplexer_unit_tb.sv
